// ===== sv/sde_pkg.sv =====
`timescale 1ns / 1ps
// Package of shared types and constants for the shadow extrema detector.
package sde_pkg;

    localparam int LEVEL_BITS   = 10;
    localparam int CHANNEL_BITS = 4;
    localparam int INDEX_BITS   = 3;
    localparam int THRESH_BITS  = 6;
    localparam int STEP_BITS    = 4;
    localparam int RECIP_BITS   = 12;
    localparam int RECIP_SHIFT  = 16;
    localparam int PROD_BITS    = LEVEL_BITS + RECIP_BITS;

    localparam logic [LEVEL_BITS-1:0]   LEVEL_MAX         = 10'd1023;
    // Ceiling of 2^16 / 26: exact quotient for every 10-bit dividend.
    localparam logic [RECIP_BITS-1:0]   THRESH_RECIP      = 12'd2521;
    localparam logic [CHANNEL_BITS-1:0] CHANNELS_PER_SIDE = 4'd8;
    localparam logic [CHANNEL_BITS-1:0] LAST_CHANNEL      = 4'd15;
    localparam logic [STEP_BITS:0]      STEP_ADD          = 5'd7;
    localparam logic [STEP_BITS:0]      STEP_MOD          = 5'd12;

    localparam logic MODE_MEASURE   = 1'b0;
    localparam logic MODE_CALIBRATE = 1'b1;

    // Classified word passed from the front part to the back part.
    typedef struct packed {
        logic                    mode;
        logic [CHANNEL_BITS-1:0] channel;
        logic [LEVEL_BITS-1:0]   level;
    } task_t;

    // Result word as presented on the output ports.
    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic                  frame_done;
        logic                  left_found;
        logic [INDEX_BITS-1:0] left_index;
        logic [LEVEL_BITS-1:0] left_min;
        logic                  right_found;
        logic [INDEX_BITS-1:0] right_index;
        logic [LEVEL_BITS-1:0] right_min;
        logic                  step_event;
        logic [STEP_BITS-1:0]  step_value;
    } result_t;

endpackage

// ===== sv/sde_fifo.sv =====
`timescale 1ns / 1ps
// Small register queue used between the parts of the shadow extrema detector.
module sde_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/sde_front.sv =====
`timescale 1ns / 1ps
// Front part: holds baselines and thresholds and conditions each incoming sample.
module sde_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic                              mode,
    input  logic [sde_pkg::CHANNEL_BITS-1:0]  channel,
    input  logic [sde_pkg::LEVEL_BITS-1:0]    sample,
    output sde_pkg::task_t                    task_word
);
    import sde_pkg::*;

    localparam int NUM_CHANNELS = 2 ** CHANNEL_BITS;

    logic [LEVEL_BITS-1:0]  baseline_reg  [NUM_CHANNELS];
    logic [THRESH_BITS-1:0] threshold_reg [NUM_CHANNELS];
    logic [PROD_BITS-1:0]   product;
    logic [THRESH_BITS-1:0] new_threshold;
    logic signed [LEVEL_BITS:0] diff;
    logic signed [LEVEL_BITS:0] thr_ext;
    logic                   shadowed;

    // Threshold is baseline / 26, done as a reciprocal multiply.
    assign product       = PROD_BITS'(sample) * PROD_BITS'(THRESH_RECIP);
    assign new_threshold = product[RECIP_SHIFT +: THRESH_BITS];

    assign diff     = $signed({1'b0, baseline_reg[channel]}) - $signed({1'b0, sample});
    assign thr_ext  = $signed({{(LEVEL_BITS + 1 - THRESH_BITS){1'b0}}, threshold_reg[channel]});
    assign shadowed = (diff >= thr_ext);

    always_comb
    begin
        task_word.mode    = mode;
        task_word.channel = channel;
        if (mode == MODE_CALIBRATE || shadowed)
        begin
            task_word.level = sample;
        end
        else
        begin
            task_word.level = LEVEL_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                baseline_reg[i]  <= '0;
                threshold_reg[i] <= '0;
            end
        end
        else if (accept && mode == MODE_CALIBRATE)
        begin
            baseline_reg[channel]  <= sample;
            threshold_reg[channel] <= new_threshold;
        end
    end

endmodule

// ===== sv/sde_back.sv =====
`timescale 1ns / 1ps
// Back part: running minima per side, frame close and the onset step counter.
module sde_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  sde_pkg::task_t     task_word,
    output sde_pkg::result_t   result
);
    import sde_pkg::*;

    logic [LEVEL_BITS-1:0] lmin_reg, lmin_next, lmin_fold;
    logic [INDEX_BITS-1:0] lidx_reg, lidx_next, lidx_fold;
    logic [LEVEL_BITS-1:0] rmin_reg, rmin_next, rmin_fold;
    logic [INDEX_BITS-1:0] ridx_reg, ridx_next, ridx_fold;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic                  latch_reg, latch_next;
    logic [STEP_BITS:0]    step_sum;
    logic [CHANNEL_BITS-1:0] right_ch;
    logic                  measure, is_left, close, lf, rf;

    assign measure  = (task_word.mode == MODE_MEASURE);
    assign is_left  = (task_word.channel < CHANNELS_PER_SIDE);
    assign close    = measure && (task_word.channel == LAST_CHANNEL);
    assign right_ch = task_word.channel - CHANNELS_PER_SIDE;
    assign step_sum = {1'b0, step_reg} + STEP_ADD;

    always_comb
    begin
        lmin_fold = lmin_reg;
        lidx_fold = lidx_reg;
        rmin_fold = rmin_reg;
        ridx_fold = ridx_reg;
        if (measure)
        begin
            if (is_left)
            begin
                if (task_word.level < lmin_reg)
                begin
                    lmin_fold = task_word.level;
                    lidx_fold = task_word.channel[INDEX_BITS-1:0];
                end
            end
            else if (task_word.level < rmin_reg)
            begin
                rmin_fold = task_word.level;
                ridx_fold = right_ch[INDEX_BITS-1:0];
            end
        end

        lf = (lmin_fold < LEVEL_MAX);
        rf = (rmin_fold < LEVEL_MAX);

        lmin_next  = lmin_fold;
        lidx_next  = lidx_fold;
        rmin_next  = rmin_fold;
        ridx_next  = ridx_fold;
        step_next  = step_reg;
        latch_next = latch_reg;

        result             = '0;
        result.level       = task_word.level;

        if (close)
        begin
            result.frame_done  = 1'b1;
            result.left_found  = lf;
            result.left_index  = lf ? lidx_fold : '0;
            result.left_min    = lmin_fold;
            result.right_found = rf;
            result.right_index = rf ? ridx_fold : '0;
            result.right_min   = rmin_fold;
            if (latch_reg)
            begin
                if (!lf && !rf)
                begin
                    latch_next = 1'b0;
                end
            end
            else if (lf || rf)
            begin
                step_next = (step_sum >= STEP_MOD) ? STEP_BITS'(step_sum - STEP_MOD)
                                                   : step_sum[STEP_BITS-1:0];
                latch_next        = 1'b1;
                result.step_event = 1'b1;
            end
            lmin_next = LEVEL_MAX;
            lidx_next = '0;
            rmin_next = LEVEL_MAX;
            ridx_next = '0;
        end
        result.step_value = step_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lmin_reg  <= LEVEL_MAX;
            lidx_reg  <= '0;
            rmin_reg  <= LEVEL_MAX;
            ridx_reg  <= '0;
            step_reg  <= '0;
            latch_reg <= 1'b0;
        end
        else if (step)
        begin
            lmin_reg  <= lmin_next;
            lidx_reg  <= lidx_next;
            rmin_reg  <= rmin_next;
            ridx_reg  <= ridx_next;
            step_reg  <= step_next;
            latch_reg <= latch_next;
        end
    end

    // The step counter stays inside its modulus.
    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < STEP_MOD[STEP_BITS-1:0])
        else $error("step counter out of range");

    // An onset event only comes with a closed frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.step_event |-> result.frame_done)
        else $error("step event outside frame close");

    // The left side, when not found, reports the idle minimum and index zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.frame_done && !result.left_found
        |-> result.left_min == LEVEL_MAX && result.left_index == '0)
        else $error("left side not found but reports a minimum");

    // After a frame closes the running minima start afresh.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && close |=> lmin_reg == LEVEL_MAX && rmin_reg == LEVEL_MAX)
        else $error("running minima not cleared at frame close");

endmodule

// ===== sv/shadow_detect_extrema.sv =====
`timescale 1ns / 1ps
// Top level of the shadow extrema detector for two sides of photodiode channels.
//
// Input channel: a word of (mode, channel, sample) is taken at a rising edge with
// push high and full low. Calibrate words store the channel's baseline and a
// threshold of baseline / 26; measure words are conditioned against them, a sample
// that is not at least the threshold below its baseline becoming 1023.
// Result channel: one word per input word, oldest first, shown while empty is low
// and taken at a rising edge with pop high. The measure word of channel 15 closes
// the frame: it reports each side's minimum and the first channel holding it, and
// steps the onset counter by 7 modulo 12 when the onset latch first sets.
// Flow: a taken word is written into the middle queue, moved by the back part into
// the output queue and shown on the result ports from there. The front part
// conditions the sample in the accepting cycle, the back part folds it into the
// running minima as it leaves the middle queue. One word per cycle is sustained
// while the receiver pops every word and the output queue does not fill.
// When the receiver stops popping, the output queue and then the middle queue fill
// and full rises; no word is lost. Reset clears all baselines and thresholds to
// zero, the running minima to 1023, the step counter and the onset latch.
module shadow_detect_extrema #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              mode,
    input  logic [sde_pkg::CHANNEL_BITS-1:0]  channel,
    input  logic [sde_pkg::LEVEL_BITS-1:0]    sample,
    input  logic                              pop,
    output logic                              empty,
    output logic [sde_pkg::LEVEL_BITS-1:0]    level,
    output logic                              frame_done,
    output logic                              left_found,
    output logic [sde_pkg::INDEX_BITS-1:0]    left_index,
    output logic [sde_pkg::LEVEL_BITS-1:0]    left_min,
    output logic                              right_found,
    output logic [sde_pkg::INDEX_BITS-1:0]    right_index,
    output logic [sde_pkg::LEVEL_BITS-1:0]    right_min,
    output logic                              step_event,
    output logic [sde_pkg::STEP_BITS-1:0]     step_value
);
    import sde_pkg::*;

    localparam int TASK_BITS   = $bits(task_t);
    localparam int RESULT_BITS = $bits(result_t);

    task_t   front_word;
    task_t   queued_word;
    result_t back_result;
    result_t out_word;

    logic                   in_take;
    logic                   mid_empty;
    logic                   out_full;
    logic                   back_step;
    logic [TASK_BITS-1:0]   mid_data;
    logic [RESULT_BITS-1:0] out_data;

    assign in_take   = push && !full;
    // The back part moves a word whenever one waits and the output queue has room.
    assign back_step = !mid_empty && !out_full;

    sde_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_take),
        .mode      (mode),
        .channel   (channel),
        .sample    (sample),
        .task_word (front_word)
    );

    sde_fifo #(
        .WIDTH (TASK_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_take),
        .push_data (front_word),
        .full      (full),
        .pop       (back_step),
        .pop_data  (mid_data),
        .empty     (mid_empty)
    );

    assign queued_word = mid_data;

    sde_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (back_step),
        .task_word (queued_word),
        .result    (back_result)
    );

    sde_fifo #(
        .WIDTH (RESULT_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (back_step),
        .push_data (back_result),
        .full      (out_full),
        .pop       (pop),
        .pop_data  (out_data),
        .empty     (empty)
    );

    assign out_word    = out_data;
    assign level       = out_word.level;
    assign frame_done  = out_word.frame_done;
    assign left_found  = out_word.left_found;
    assign left_index  = out_word.left_index;
    assign left_min    = out_word.left_min;
    assign right_found = out_word.right_found;
    assign right_index = out_word.right_index;
    assign right_min   = out_word.right_min;
    assign step_event  = out_word.step_event;
    assign step_value  = out_word.step_value;

endmodule
